[design/msct_pkg.sv]
// -----------------------------------------------------------------------------
// msct_pkg: shared types and constants
// Operation codes, field widths and the command and status bundles that
// connect the controller to the datapath.
// -----------------------------------------------------------------------------
package msct_pkg;

   localparam int OP_W    = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 7;

   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
   localparam logic [OP_W-1:0] OP_COUNT   = 3'd2;
   localparam logic [OP_W-1:0] OP_RESTART = 3'd3;
   localparam logic [OP_W-1:0] OP_STEP    = 3'd4;
   localparam logic [OP_W-1:0] OP_READ    = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the accepted request
      logic scan;     // one step of the walk over the stored entries
      logic fetch;    // read the entry under the iterator
      logic finish;   // commit state updates and load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_scan;   // incoming request walks the store
      logic req_fetch;  // incoming request needs a store read first
      logic scan_done;  // walk finished, last read data consumed
      logic rsp_free;   // response register can take a new result
   } status_type;

endpackage

[design/msct_ram.sv]
// -----------------------------------------------------------------------------
// msct_ram: generic simple dual-port RAM
// One write port and one read port, read data registered on read enable.
// -----------------------------------------------------------------------------
module msct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/msct_ctrl.sv]
// -----------------------------------------------------------------------------
// msct_ctrl: sequencing controller
// Accepts one request at a time, runs the store walk or the iterator read
// and hands the result to the response register.
// -----------------------------------------------------------------------------
module msct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  msct_pkg::status_type  st,
   output msct_pkg::cmd_type     cmd
);
   import msct_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FETCH = 4'b0100,
      ST_RESP  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (st.req_scan) begin
                  state_in = ST_SCAN;
               end else if (st.req_fetch) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            if (st.scan_done) begin
               state_in = ST_RESP;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            // Hold the result until the response register has drained.
            if (st.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_fetch_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |=> state_ff == ST_RESP)
      else $error("iterator read did not proceed to the response state");

endmodule

[design/msct_dp.sv]
// -----------------------------------------------------------------------------
// msct_dp: datapath
// Entry store, entry count, iterator, walk counters and response register.
// -----------------------------------------------------------------------------
module msct_dp #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  msct_pkg::cmd_type                   cmd,
   output msct_pkg::status_type                st,
   input  logic [msct_pkg::OP_W-1:0]           req_op,
   input  logic signed [msct_pkg::VALUE_W-1:0] req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [msct_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic signed [msct_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                                rsp_at_end
);
   import msct_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);

   logic [OP_W-1:0]    op_ff;
   logic [VALUE_W-1:0] val_ff;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   iter_ff, iter_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   keep_ff, keep_in;
   logic [CNT_W-1:0]   hit_ff, hit_in;
   logic               pend_ff, pend_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0] rsp_read_ff, rsp_read_in;
   logic               rsp_at_end_ff, rsp_at_end_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   logic [CNT_W-1:0]   iter_m1;
   logic               full;
   logic               more;
   logic               hit_now;
   logic               keep_wr;
   logic               ins_wr;

   assign iter_m1 = iter_ff - 1'b1;
   assign full    = total_ff == CNT_W'(CAPACITY);
   assign more    = rd_idx_ff < total_ff;
   assign hit_now = ram_rd_data == val_ff;
   assign keep_wr = cmd.scan && pend_ff && !hit_now && (op_ff == OP_REMOVE);
   assign ins_wr  = cmd.finish && (op_ff == OP_INSERT) && !full;

   assign st.req_scan  = (req_op == OP_REMOVE) || (req_op == OP_COUNT);
   assign st.req_fetch = (req_op == OP_READ) && (iter_ff != '0);
   assign st.scan_done = !more && !pend_ff;
   assign st.rsp_free  = !rsp_valid_ff || rsp_ready;

   // Survivors of a remove are written back at the keep index, which never
   // passes the read index, so the walk compacts the store in place.
   assign ram_wr_en   = keep_wr || ins_wr;
   assign ram_wr_addr = ins_wr ? total_ff[ADDR_W-1:0] : keep_ff[ADDR_W-1:0];
   assign ram_wr_data = ins_wr ? val_ff : ram_rd_data;
   assign ram_rd_en   = (cmd.scan && more) || cmd.fetch;
   assign ram_rd_addr = cmd.fetch ? iter_m1[ADDR_W-1:0] : rd_idx_ff[ADDR_W-1:0];

   msct_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Walk counters.
   always_comb begin
      rd_idx_in = rd_idx_ff;
      keep_in   = keep_ff;
      hit_in    = hit_ff;
      pend_in   = pend_ff;
      if (cmd.load) begin
         rd_idx_in = '0;
         keep_in   = '0;
         hit_in    = '0;
         pend_in   = 1'b0;
      end else if (cmd.scan) begin
         pend_in = more;
         if (more) begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         if (pend_ff) begin
            if (hit_now) begin
               hit_in = hit_ff + 1'b1;
            end else begin
               keep_in = keep_ff + 1'b1;
            end
         end
      end
   end

   // Commit and result.
   always_comb begin
      total_in      = total_ff;
      iter_in       = iter_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_at_end_in = rsp_at_end_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b1;
         rsp_count_in = '0;
         rsp_read_in  = '0;
         case (op_ff)
            OP_INSERT: begin
               if (full) begin
                  rsp_ok_in = 1'b0;
               end else begin
                  total_in = total_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               total_in     = keep_ff;
               iter_in      = '0;
               rsp_count_in = COUNT_W'(hit_ff);
            end
            OP_COUNT: begin
               rsp_count_in = COUNT_W'(hit_ff);
            end
            OP_RESTART: begin
               iter_in = total_ff;
            end
            OP_STEP: begin
               if (iter_ff != '0) begin
                  iter_in = iter_m1;
               end
            end
            OP_READ: begin
               if (iter_ff != '0) begin
                  rsp_read_in = ram_rd_data;
               end
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
         rsp_at_end_in = iter_in == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         iter_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         iter_ff      <= iter_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         val_ff <= req_item_value;
      end
      rd_idx_ff     <= rd_idx_in;
      keep_ff       <= keep_in;
      hit_ff        <= hit_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_at_end_ff <= rsp_at_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_at_end      = rsp_at_end_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= total_ff)
      else $error("iterator points past the newest entry");

   a_remove_ends_iter: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && (op_ff == OP_REMOVE) |=> rsp_valid_ff && rsp_at_end_ff)
      else $error("remove left the iterator on an entry");

endmodule

[design/multiset_count_table.sv]
// -----------------------------------------------------------------------------
// multiset_count_table: bounded multiset of signed 32-bit values
// Insert, remove-all, count and a newest-first iterator over a RAM store.
//
//   Channel   Direction   Handshake               Payload
//   req_      in          req_valid / req_ready   req_op, req_item_value
//   rsp_      out         rsp_valid / rsp_ready   rsp_ok, rsp_match_count,
//                                                 rsp_read_value, rsp_at_end
//
// One request is in flight at a time. Insert, restart, step, unknown codes
// and an iterator read at the end go straight to the response state; any
// other iterator read first reads the store. Remove and count walk the
// store at one RAM read per cycle, then compare the last word and see the
// walk finish before the response state. The result sits in an output
// register, so a stalled response delays only the commit of the following
// request. Reset empties the store and parks the iterator at the end; no
// clearing pass is needed.
// -----------------------------------------------------------------------------
module multiset_count_table #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [msct_pkg::OP_W-1:0]           req_op,
   input  logic signed [msct_pkg::VALUE_W-1:0] req_item_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [msct_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic signed [msct_pkg::VALUE_W-1:0] rsp_read_value,
   output logic                                rsp_at_end
);
   import msct_pkg::*;

   cmd_type    cmd;
   status_type st;

   msct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   msct_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_op          (req_op),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_match_count (rsp_match_count),
      .rsp_read_value  (rsp_read_value),
      .rsp_at_end      (rsp_at_end)
   );

endmodule
